/* hdl/bfpa_pkg.sv */
package bfpa_pkg;

  localparam int unsigned OpWidth    = 1;
  localparam int unsigned SlotWidth  = 4;
  localparam int unsigned SpaceWidth = 16;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned StatWidth  = 2;

  localparam logic [CountWidth-1:0] CountReset = 5'd16;

  typedef enum logic [OpWidth-1:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [StatWidth-1:0] {
    ST_LOADED  = 2'd0,
    ST_GRANTED = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_BADSLOT = 2'd3
  } status_e;

  // search token handed from cell to cell; index of the best cell travels beside it
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [SpaceWidth-1:0] space;
  } tok_t;

endpackage

/* hdl/bfpa_cfg_if.sv */
interface bfpa_cfg_if import bfpa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CountWidth-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/bfpa_req_if.sv */
interface bfpa_req_if import bfpa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OpWidth-1:0]    operation;
  logic [SlotWidth-1:0]  slot;
  logic [SpaceWidth-1:0] amount;

  modport source (output valid, output operation, output slot, output amount, input ready);
  modport sink (input valid, input operation, input slot, input amount, output ready);
endinterface

/* hdl/bfpa_rsp_if.sv */
interface bfpa_rsp_if import bfpa_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [StatWidth-1:0]  status;
  logic [SlotWidth-1:0]  chosen_slot;
  logic [SpaceWidth-1:0] space_left;

  modport source (output valid, output status, output chosen_slot, output space_left,
                  input ready);
  modport sink (input valid, input status, input chosen_slot, input space_left,
                output ready);
endinterface

/* hdl/best_fit_partition_allocator.sv */
// Best-fit partition allocator. Each partition's free space sits in one cell of a
// chain of NUM_PARTITIONS cells. A load item with a slot below the partition count
// and the chain length writes one cell; its result passes through the pending
// registers to the output register. A request item launches a search token that
// moves one cell per cycle down the chain, keeping the smallest fitting space seen
// so far; when it leaves the chain, its result is captured in the pending registers
// and then moves to the output register. One item is worked on at a time; a finished
// result waits in the output register without blocking acceptance of the next item,
// but that item's result waits until the previous one is taken. Entries never loaded
// are undefined and must not take part in a search. The partition count register
// must be written only while no item is in flight; the block does not enforce it.
module best_fit_partition_allocator import bfpa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfpa_cfg_if.sink   cfg_i,
  bfpa_req_if.sink   req_i,
  bfpa_rsp_if.source rsp_o
);

  localparam int unsigned IdxWidth = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [CountWidth-1:0] count_q;
  logic                  start_q;
  logic [SpaceWidth-1:0] amount_q;

  status_e               pend_status_q;
  logic [SlotWidth-1:0]  pend_slot_q;
  logic [SpaceWidth-1:0] pend_space_q;
  logic                  pend_we_q;
  logic [IdxWidth-1:0]   pend_widx_q;

  logic                  rsp_valid_q;
  status_e               rsp_status_q;
  logic [SlotWidth-1:0]  rsp_slot_q;
  logic [SpaceWidth-1:0] rsp_space_q;

  tok_t                  tok [NUM_PARTITIONS+1];
  logic [IdxWidth-1:0]   idx [NUM_PARTITIONS+1];
  logic [NUM_PARTITIONS-1:0] tok_vld;
  logic [NUM_PARTITIONS-1:0] cell_en;
  logic [NUM_PARTITIONS-1:0] cell_we;

  logic                  req_acc;
  logic                  commit;
  logic                  load_ok;
  logic [SpaceWidth-1:0] left;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign commit      = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign load_ok = (32'(req_i.slot) < 32'(NUM_PARTITIONS)) &&
                   ({1'b0, req_i.slot} < count_q);

  assign tok[0] = '{valid: start_q, found: 1'b0, space: '0};
  assign idx[0] = '0;

  for (genvar g = 0; g < NUM_PARTITIONS; g++) begin : g_cell
    assign cell_en[g] = (32'(count_q) > 32'(g));
    assign cell_we[g] = commit && pend_we_q && (pend_widx_q == IdxWidth'(g));
    assign tok_vld[g] = tok[g+1].valid;

    bfpa_cell #(
      .IdxWidth (IdxWidth),
      .CellIdx  (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (cell_en[g]),
      .amount_i (amount_q),
      .we_i     (cell_we[g]),
      .wdata_i  (pend_space_q),
      .tok_i    (tok[g]),
      .idx_i    (idx[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (idx[g+1])
    );
  end

  assign left = tok[NUM_PARTITIONS].space - amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CountReset;
      start_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      start_q <= req_acc && (op_e'(req_i.operation) == OP_REQUEST);
      if (cfg_i.valid) begin
        count_q <= cfg_i.data;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            if (op_e'(req_i.operation) == OP_REQUEST) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (tok[NUM_PARTITIONS].valid) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload side of the item and result registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      amount_q <= req_i.amount;
      if (op_e'(req_i.operation) == OP_LOAD) begin
        pend_slot_q <= req_i.slot;
        pend_widx_q <= IdxWidth'(req_i.slot);
        if (load_ok) begin
          pend_status_q <= ST_LOADED;
          pend_space_q  <= req_i.amount;
          pend_we_q     <= 1'b1;
        end else begin
          pend_status_q <= ST_BADSLOT;
          pend_space_q  <= '0;
          pend_we_q     <= 1'b0;
        end
      end
    end
    if (state_q == S_SCAN && tok[NUM_PARTITIONS].valid) begin
      if (tok[NUM_PARTITIONS].found) begin
        pend_status_q <= ST_GRANTED;
        pend_slot_q   <= SlotWidth'(idx[NUM_PARTITIONS]);
        pend_space_q  <= left;
        pend_we_q     <= 1'b1;
        pend_widx_q   <= idx[NUM_PARTITIONS];
      end else begin
        pend_status_q <= ST_NOFIT;
        pend_slot_q   <= '0;
        pend_space_q  <= '0;
        pend_we_q     <= 1'b0;
      end
    end
    if (commit) begin
      rsp_status_q <= pend_status_q;
      rsp_slot_q   <= pend_slot_q;
      rsp_space_q  <= pend_space_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.chosen_slot = rsp_slot_q;
  assign rsp_o.space_left  = rsp_space_q;

`ifndef SYNTHESIS
  // at most one search token is in the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one search token in the chain");

  // a token only leaves the chain during a scan
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NUM_PARTITIONS].valid |-> (state_q == S_SCAN))
    else $error("search token outside of a scan");

  // a search is launched only right after a request was taken
  a_start_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == S_SCAN) && $past(req_acc))
    else $error("search launched without a request");

  // the table is written only at a real partition
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && pend_we_q) |-> (32'(pend_widx_q) < 32'(NUM_PARTITIONS)))
    else $error("table write beyond the partitions");
`endif

endmodule

/* hdl/bfpa_cell.sv */
module bfpa_cell import bfpa_pkg::*; #(
  parameter int unsigned IdxWidth = 4,
  parameter int unsigned CellIdx  = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [SpaceWidth-1:0] amount_i,
  input  logic                  we_i,
  input  logic [SpaceWidth-1:0] wdata_i,
  input  tok_t                  tok_i,
  input  logic [IdxWidth-1:0]   idx_i,
  output tok_t                  tok_o,
  output logic [IdxWidth-1:0]   idx_o
);

  logic [SpaceWidth-1:0] space_q;
  tok_t                  tok_d;
  logic                  valid_q;
  logic                  found_q;
  logic [SpaceWidth-1:0] best_q;
  logic [IdxWidth-1:0]   idx_d, idx_q;
  logic                  take;

  // strict less-than keeps the lower index on a tie
  assign take = tok_i.valid && en_i && (space_q >= amount_i) &&
                (!tok_i.found || (space_q < tok_i.space));

  always_comb begin
    tok_d = tok_i;
    idx_d = idx_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.space = space_q;
      idx_d       = IdxWidth'(CellIdx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      space_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= tok_d.found;
    best_q  <= tok_d.space;
    idx_q   <= idx_d;
  end

  assign tok_o = '{valid: valid_q, found: found_q, space: best_q};
  assign idx_o = idx_q;

endmodule

/* tb/bfpa_fit_checker.sv */
module bfpa_fit_checker import bfpa_pkg::*; #(
  parameter int unsigned NUM_PARTITIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfpa_cfg_if  cfg_i,
  bfpa_req_if  req_i,
  bfpa_rsp_if  rsp_i,
  output int   err_count_o,
  output int   pending_o,
  output int   granted_o,
  output int   nofit_o,
  output int   rejected_o
);

  typedef struct packed {
    status_e               status;
    logic [SlotWidth-1:0]  slot;
    logic [SpaceWidth-1:0] space;
  } outcome_t;

  logic [SpaceWidth-1:0] part_space [NUM_PARTITIONS];
  logic [CountWidth-1:0] part_count;
  outcome_t              outcome_q [$];
  int                    errs;
  int                    n_granted;
  int                    n_nofit;
  int                    n_rejected;

  // applies one item to the local copy of the table and returns its outcome
  function automatic outcome_t best_fit_outcome(input op_e                   op,
                                                input logic [SlotWidth-1:0]  slot,
                                                input logic [SpaceWidth-1:0] amount);
    outcome_t              res;
    int unsigned           lim;
    int unsigned           best;
    logic [SpaceWidth-1:0] best_space;
    bit                    found;
    lim        = (part_count > NUM_PARTITIONS) ? NUM_PARTITIONS : part_count;
    best       = 0;
    best_space = '0;
    found      = 1'b0;
    res        = '{ST_NOFIT, '0, '0};
    if (op == OP_LOAD) begin
      if (slot < lim) begin
        part_space[slot] = amount;
        res = '{ST_LOADED, slot, amount};
      end else begin
        res = '{ST_BADSLOT, slot, '0};
      end
    end else begin
      for (int unsigned i = 0; i < lim; i++) begin
        // strict less-than keeps the lowest index on a tie
        if (part_space[i] >= amount && (!found || part_space[i] < best_space)) begin
          found      = 1'b1;
          best       = i;
          best_space = part_space[i];
        end
      end
      if (found) begin
        best_space       = best_space - amount;
        part_space[best] = best_space;
        res = '{ST_GRANTED, SlotWidth'(best), best_space};
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      part_count = CountReset;
      outcome_q.delete();
      errs       = 0;
      n_granted  = 0;
      n_nofit    = 0;
      n_rejected = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{status_e'(rsp_i.status), rsp_i.chosen_slot, rsp_i.space_left};
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected item status %0d slot %0d space %0d", $time,
                   got.status, got.slot, got.space);
          errs++;
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.space !== want.space) begin
            $display("%0t: mismatch expected status %0d slot %0d space %0d,",
                     $time, want.status, want.slot, want.space,
                     " got status %0d slot %0d space %0d",
                     got.status, got.slot, got.space);
            errs++;
          end else begin
            case (want.status)
              ST_GRANTED: n_granted++;
              ST_NOFIT:   n_nofit++;
              ST_BADSLOT: n_rejected++;
              default: ;
            endcase
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        part_count = cfg_i.data;
      end
      if (req_i.valid && req_i.ready) begin
        outcome_q.push_back(best_fit_outcome(op_e'(req_i.operation), req_i.slot,
                                             req_i.amount));
      end
    end
    err_count_o <= errs;
    pending_o   <= outcome_q.size();
    granted_o   <= n_granted;
    nofit_o     <= n_nofit;
    rejected_o  <= n_rejected;
  end

endmodule

/* tb/tb_best_fit_partition_allocator.sv */
module tb_best_fit_partition_allocator import bfpa_pkg::*;;

  localparam int unsigned NumParts   = 16;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned PhaseItems = 180;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;
  int   err_count;
  int   pending;
  int   n_granted;
  int   n_nofit;
  int   n_rejected;
  int   items_sent;
  int   settings_used;
  int   active_parts;
  int   quiet_cycles = 0;

  bfpa_cfg_if cfg_if ();
  bfpa_req_if req_if ();
  bfpa_rsp_if rsp_if ();

  best_fit_partition_allocator #(
    .NUM_PARTITIONS(NumParts)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  bfpa_fit_checker #(
    .NUM_PARTITIONS(NumParts)
  ) i_fit_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_if),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .err_count_o(err_count),
    .pending_o  (pending),
    .granted_o  (n_granted),
    .nofit_o    (n_nofit),
    .rejected_o (n_rejected)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [SpaceWidth-1:0] rand_space();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SpaceWidth'($urandom_range(15) * 4);  // narrow set makes ties
      default: return SpaceWidth'($urandom);
    endcase
  endfunction

  function automatic logic [SpaceWidth-1:0] rand_request();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SpaceWidth'($urandom_range(63));
      4, 5:    return SpaceWidth'($urandom_range(4095));
      default: return SpaceWidth'($urandom);
    endcase
  endfunction

  task automatic issue_item(input op_e                   op,
                            input logic [SlotWidth-1:0]  slot,
                            input logic [SpaceWidth-1:0] amount);
    if (!calm && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.slot      <= slot;
    req_if.amount    <= amount;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    // wait first so that an item accepted just now shows up in the count
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_part_count(input logic [CountWidth-1:0] n);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= n;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    active_parts = (n > NumParts) ? NumParts : n;
    settings_used++;
  endtask

  task automatic run_phase(input int unsigned n_items);
    logic [SlotWidth-1:0] slot;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k == n_items / 2) begin
        drain_results();
      end
      if ($urandom_range(99) < 40) begin
        if (active_parts != 0 && $urandom_range(99) < 85) begin
          slot = SlotWidth'($urandom_range(active_parts - 1));
        end else begin
          slot = SlotWidth'($urandom_range(NumParts - 1));
        end
        issue_item(OP_LOAD, slot, rand_space());
      end else begin
        issue_item(OP_REQUEST, SlotWidth'($urandom), rand_request());
      end
    end
  endtask

  initial begin
    logic [SpaceWidth-1:0] amount;
    rst_ni           <= 1'b0;
    calm             <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_LOAD;
    req_if.slot      <= '0;
    req_if.amount    <= '0;
    items_sent    = 0;
    settings_used = 0;
    active_parts  = NumParts;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every entry is written before the first search can read it
    for (int i = 0; i < NumParts; i++) begin
      if (i == 1) begin
        amount = '0;
      end else if (i == 2) begin
        amount = '1;
      end else if (i == 3 || i == 7) begin
        amount = 16'd40;
      end else begin
        amount = SpaceWidth'(i * 3000 + 500);
      end
      issue_item(OP_LOAD, SlotWidth'(i), amount);
    end
    issue_item(OP_REQUEST, '0, '0);        // zero request takes the smallest, unchanged
    issue_item(OP_REQUEST, '1, 16'd35);    // tie between two entries
    issue_item(OP_REQUEST, 4'd9, '1);      // only the full entry fits
    issue_item(OP_REQUEST, 4'd6, '1);      // nothing fits now

    // no partitions in use
    set_part_count(5'd0);
    issue_item(OP_REQUEST, 4'd3, 16'd1);
    issue_item(OP_LOAD, 4'd0, 16'd77);

    // count above the table size is clamped
    set_part_count('1);
    issue_item(OP_LOAD, 4'd15, '1);
    issue_item(OP_REQUEST, 4'd0, '1);

    set_part_count(5'd1);
    issue_item(OP_LOAD, 4'd5, 16'h1234);
    issue_item(OP_REQUEST, 4'd10, 16'd1);

    set_part_count(CountWidth'(NumParts));
    run_phase(PhaseItems);
    set_part_count(5'd1);
    run_phase(PhaseItems);
    set_part_count(5'd31);
    run_phase(PhaseItems);
    set_part_count(5'd0);
    run_phase(PhaseItems / 4);
    for (int p = 0; p < 3; p++) begin
      set_part_count(CountWidth'($urandom_range(2, 31)));
      run_phase(PhaseItems);
    end

    // long stretch without gaps or stalls on either side
    calm <= 1'b1;
    set_part_count(CountWidth'(NumParts));
    run_phase(PhaseItems);
    calm <= 1'b0;

    drain_results();
    repeat (3 * NumParts) @(posedge clk_i);
    $display("sent %0d items under %0d partition-count settings", items_sent, settings_used);
    $display("outcomes: %0d granted, %0d no fit, %0d rejected loads",
             n_granted, n_nofit, n_rejected);
    if (pending != 0) begin
      $display("%0d expected items never arrived", pending);
    end
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
